@@ rtl/core/zqrl_pkg.sv @@
// Shared types and constants for the zigzag quantizer and run-level coder.
// Holds the zigzag scan table, result kind codes and the divider request type.
// No dependencies.
package zqrl_pkg;

  localparam int DIV_W         = 16;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;
  localparam int DSR_W         = 6;
  localparam int REM_W         = DSR_W + 1;

  localparam logic [1:0] KIND_DC    = 2'd0;
  localparam logic [1:0] KIND_SYM   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [DSR_W-1:0] DC_DIVISOR = 6'd8;
  localparam logic [6:0] AC_MAX  = 7'd127;
  localparam logic [7:0] DC_MAX  = 8'd254;
  localparam logic [7:0] DC_MID  = 8'd128;
  localparam logic [7:0] DC_ESC  = 8'd255;

  // Raster index of each zigzag scan position.
  localparam logic [5:0] ZZ_RASTER [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/core/zigzag_quantize_run_level.sv @@
// Top level of the zigzag quantizer and run-level coder for 8x8 blocks.
// Depends on zqrl_pkg and zqrl_div.
//
//   port group | direction | contents
//   in_        | slave     | tdata: coefficient; tuser: intra_block
//   out_       | master    | tdata: level, run, sign, last_coefficient, nonzero_count;
//              |           | tuser: kind; tlast: last_of_run
//   cfg_       | write     | data: quantizer
//
// A block loads 64 input words, one per cycle.
// Each coefficient then goes through a store read, a divider load, the divider
// iterations at four bits each, then write-back; one shared divider serves them all.
// The scan reads each coefficient and then checks it, and waits on any output stall.
// Reset clears control state; quantizer resets to 8. Input is ready only while loading.
module zigzag_quantize_run_level #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((COEF_WIDTH+7)/8)*8-1:0]     in_tdata,  // coefficient
  input  logic [0:0]                          in_tuser,  // intra_block
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // level, run, sign, last_coefficient, nonzero_count, zero pad
  output logic [23:0]                         out_tdata,
  output logic [1:0]                          out_tuser, // kind
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [4:0]                          cfg_data
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_HEAD = 3'd4;
  localparam logic [2:0] ST_SRD  = 3'd5;
  localparam logic [2:0] ST_SCHK = 3'd6;

  logic [2:0]  state_r;
  logic [5:0]  ld_cnt_r, k_r, run_r;
  logic [6:0]  count_r, seen_r;
  logic        intra_r, neg_r;
  logic [4:0]  quant_r;
  logic [7:0]  dc_r;
  logic        out_valid_r, out_last_r, out_lastc_r, out_sign_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_level_r;
  logic [5:0]  out_run_r;
  logic [6:0]  out_count_r;

  logic signed [COEF_WIDTH-1:0] store_mem [64];
  logic signed [COEF_WIDTH-1:0] store_rd_r;
  logic [7:0]  q_mem [64];
  logic [7:0]  q_rd_r;

  logic                          in_acc, out_free, out_load, is_dc, div_done, fin;
  logic [COEF_WIDTH-1:0]         coef, mag;
  logic [zqrl_pkg::DIV_W-1:0]    div_quo;
  logic [zqrl_pkg::DSR_W-1:0]    ac_div;
  logic [6:0]                    ac_mag;
  logic [7:0]                    qval, dc_clip, dc_val;
  zqrl_pkg::div_req_t            div_req;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign coef      = in_tdata[COEF_WIDTH-1:0];
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = out_free &&
                     ((state_r == ST_HEAD && (intra_r || count_r == '0)) ||
                      (state_r == ST_SCHK && q_rd_r[6:0] != '0));
  assign is_dc     = intra_r && (k_r == '0);
  assign fin       = (seen_r + 7'd1) == count_r;

  assign mag    = store_rd_r[COEF_WIDTH-1] ? (~store_rd_r + 1'b1) : store_rd_r;
  assign ac_div = (quant_r == '0) ? 6'd2 : {quant_r, 1'b0};

  assign div_req.start    = (state_r == ST_DIV);
  assign div_req.dividend = zqrl_pkg::DIV_W'(mag);
  assign div_req.divisor  = is_dc ? zqrl_pkg::DC_DIVISOR : ac_div;

  zqrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    ac_mag = (div_quo > zqrl_pkg::DIV_W'(zqrl_pkg::AC_MAX)) ? zqrl_pkg::AC_MAX
                                                             : div_quo[6:0];
    qval   = {neg_r && (ac_mag != '0), ac_mag};
    if (neg_r || div_quo == '0) begin
      dc_clip = 8'd1;
    end else if (div_quo > zqrl_pkg::DIV_W'(zqrl_pkg::DC_MAX)) begin
      dc_clip = zqrl_pkg::DC_MAX;
    end else begin
      dc_clip = div_quo[7:0];
    end
    dc_val = (dc_clip == zqrl_pkg::DC_MID) ? zqrl_pkg::DC_ESC : dc_clip;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store_mem[ld_cnt_r] <= $signed(coef);
    end
    store_rd_r <= store_mem[zqrl_pkg::ZZ_RASTER[k_r]];
    if (state_r == ST_WAIT && div_done) begin
      q_mem[k_r] <= qval;
    end
    q_rd_r <= q_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      neg_r <= store_rd_r[COEF_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ld_cnt_r    <= '0;
      k_r         <= '0;
      run_r       <= '0;
      count_r     <= '0;
      seen_r      <= '0;
      intra_r     <= 1'b0;
      quant_r     <= 5'd8;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        quant_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (ld_cnt_r == '0) begin
              intra_r <= in_tuser[0];
            end
            ld_cnt_r <= ld_cnt_r + 6'd1;
            if (ld_cnt_r == 6'd63) begin
              state_r <= ST_RD;
              k_r     <= '0;
              count_r <= '0;
            end
          end
        end
        ST_RD:   state_r <= ST_DIV;
        ST_DIV:  state_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            if (is_dc) begin
              dc_r <= dc_val;
            end else if (ac_mag != '0) begin
              count_r <= count_r + 7'd1;
            end
            k_r     <= k_r + 6'd1;
            state_r <= (k_r == 6'd63) ? ST_HEAD : ST_RD;
          end
        end
        ST_HEAD: begin
          run_r  <= '0;
          seen_r <= '0;
          if (out_free) begin
            if (intra_r) begin
              out_kind_r  <= zqrl_pkg::KIND_DC;
              out_level_r <= dc_r;
              out_run_r   <= '0;
              out_sign_r  <= 1'b0;
              out_lastc_r <= 1'b0;
              out_count_r <= count_r;
              out_last_r  <= (count_r == '0);
              k_r         <= 6'd1;
              state_r     <= (count_r == '0) ? ST_LOAD : ST_SRD;
            end else if (count_r == '0) begin
              out_kind_r  <= zqrl_pkg::KIND_EMPTY;
              out_level_r <= '0;
              out_run_r   <= '0;
              out_sign_r  <= 1'b0;
              out_lastc_r <= 1'b0;
              out_count_r <= '0;
              out_last_r  <= 1'b1;
              state_r     <= ST_LOAD;
            end else begin
              k_r     <= '0;
              state_r <= ST_SRD;
            end
          end
        end
        ST_SRD:  state_r <= ST_SCHK;
        ST_SCHK: begin
          if (q_rd_r[6:0] == '0) begin
            run_r   <= run_r + 6'd1;
            k_r     <= k_r + 6'd1;
            state_r <= (k_r == 6'd63) ? ST_LOAD : ST_SRD;
          end else if (out_free) begin
            out_kind_r  <= zqrl_pkg::KIND_SYM;
            out_level_r <= {1'b0, q_rd_r[6:0]};
            out_run_r   <= run_r;
            out_sign_r  <= q_rd_r[7];
            out_lastc_r <= fin;
            out_count_r <= count_r;
            out_last_r  <= fin;
            seen_r      <= seen_r + 7'd1;
            run_r       <= '0;
            k_r         <= k_r + 6'd1;
            state_r     <= (fin || k_r == 6'd63) ? ST_LOAD : ST_SRD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_count_r, out_lastc_r, out_sign_r, out_run_r, out_level_r};

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_WAIT)
    else $error("divider finished outside its wait state");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCHK |-> seen_r < count_r)
    else $error("more symbols scanned than nonzero coefficients");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == zqrl_pkg::KIND_EMPTY |-> out_tlast)
    else $error("empty block word without end of block");

endmodule

@@ rtl/core/zqrl_div.sv @@
// Iterative unsigned divider, four quotient bits per cycle.
// Depends on zqrl_pkg for widths and the request type.
module zqrl_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  zqrl_pkg::div_req_t      req,
  output logic                    done,
  output logic [zqrl_pkg::DIV_W-1:0] quotient
);

  logic [zqrl_pkg::DIV_W-1:0] acc_r, quo_r, acc_nxt, quo_nxt;
  logic [zqrl_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [zqrl_pkg::DSR_W-1:0] dsr_r;
  logic [2:0]                 cnt_r;
  logic                       busy_r, done_r;

  always_comb begin
    logic [zqrl_pkg::REM_W-1:0] r;
    logic [zqrl_pkg::DIV_W-1:0] a, q;
    r = rem_r;
    a = acc_r;
    q = quo_r;
    for (int i = 0; i < zqrl_pkg::DIV_STEP_BITS; i++) begin
      r = {r[zqrl_pkg::REM_W-2:0], a[zqrl_pkg::DIV_W-1]};
      a = {a[zqrl_pkg::DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dsr_r}) begin
        r = r - {1'b0, dsr_r};
        q = {q[zqrl_pkg::DIV_W-2:0], 1'b1};
      end else begin
        q = {q[zqrl_pkg::DIV_W-2:0], 1'b0};
      end
    end
    rem_nxt = r;
    acc_nxt = a;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'(zqrl_pkg::DIV_CYCLES - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ bench/zigzag_quantize_run_level_test.sv @@
// Self-checking bench for the zigzag quantizer and run-level coder.
// Predicts every result word from the loaded coefficients and the quantizer setting.
// Depends on zqrl_pkg and the zigzag_quantize_run_level RTL.
`timescale 1ns / 100ps

class block_scoreboard;
  logic [15:0] coefs [64];
  int unsigned load_idx;
  bit intra;
  logic [4:0] quantizer;
  logic [1:0] kind_q [$];
  logic [23:0] data_q [$];
  logic last_q [$];
  int mismatches;
  int words_checked;

  function new();
    load_idx = 0;
    intra = 0;
    quantizer = 5'd8;
    mismatches = 0;
    words_checked = 0;
  endfunction

  function void push_word(logic [1:0] k, int lvl, int run, bit sgn, bit lastc,
                          int cnt, bit lastr);
    kind_q.push_back(k);
    data_q.push_back({1'b0, cnt[6:0], lastc, sgn, run[5:0], lvl[7:0]});
    last_q.push_back(lastr);
  endfunction

  function void quantize_block();
    int zz [64];
    int dv, first, cnt, run, seen, v;
    dv = 2 * ((quantizer == 0) ? 1 : quantizer);
    for (int i = 0; i < 64; i++) zz[i] = $signed(coefs[zqrl_pkg::ZZ_RASTER[i]]);
    first = intra ? 1 : 0;
    cnt = 0;
    if (intra) begin
      v = zz[0] / 8;
      if (v < 1) v = 1;
      if (v > 254) v = 254;
      if (v == 128) v = 255;
      zz[0] = v;
    end
    for (int i = first; i < 64; i++) begin
      v = zz[i] / dv;
      if (v < -127) v = -127;
      if (v > 127) v = 127;
      zz[i] = v;
      if (v != 0) cnt++;
    end
    if (intra) begin
      push_word(zqrl_pkg::KIND_DC, zz[0], 0, 0, 0, cnt, cnt == 0);
    end else if (cnt == 0) begin
      push_word(zqrl_pkg::KIND_EMPTY, 0, 0, 0, 0, 0, 1);
      return;
    end
    run = 0;
    seen = 0;
    for (int i = first; i < 64; i++) begin
      if (zz[i] == 0) begin
        run++;
      end else begin
        seen++;
        push_word(zqrl_pkg::KIND_SYM, zz[i] < 0 ? -zz[i] : zz[i], run, zz[i] < 0, 0,
                  cnt, seen == cnt);
        if (seen == cnt) data_q[$][15] = 1'b1;
        run = 0;
      end
    end
  endfunction

  function void note_coefficient(logic [15:0] c, bit intra_in);
    if (load_idx == 0) intra = intra_in;
    coefs[load_idx] = c;
    load_idx = (load_idx + 1) % 64;
    if (load_idx == 0) quantize_block();
  endfunction

  function void check_word(logic [1:0] k, logic [23:0] d, logic l);
    logic [1:0] ek;
    logic [23:0] ed;
    logic el;
    words_checked++;
    if (kind_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected word kind=%0d data=%h", k, d);
      return;
    end
    ek = kind_q.pop_front();
    ed = data_q.pop_front();
    el = last_q.pop_front();
    if (k !== ek || d !== ed || l !== el) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected kind=%0d data=%h last=%0d, got kind=%0d data=%h last=%0d",
                 ek, ed, el, k, d, l);
    end
  endfunction
endclass

module zigzag_quantize_run_level_test;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  block_scoreboard sb = new();
  int cycles = 0;
  bit hold_off = 0;
  int blocks_sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  zigzag_quantize_run_level dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stalls in a pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata, out_tlast);
    out_tready <= !hold_off && ((cycles % 23) < 15 || $urandom_range(0, 3) == 0);
  end

  task automatic send_coefficient(logic [15:0] c, bit intra_in);
    in_tvalid <= 1;
    in_tdata <= c;
    in_tuser <= intra_in;
    do @(posedge clk); while (!in_tready);
    sb.note_coefficient(c, intra_in);
  endtask

  // Sender in bursts; kind 0 sparse small, 1 full range, 2 near-zero, 3 all zero.
  task automatic send_block(bit intra_in, int style, int dc);
    int gap;
    logic [15:0] c;
    for (int i = 0; i < 64; i++) begin
      case (style)
        0: c = ($urandom_range(0, 5) == 0) ? 16'($signed($urandom_range(0, 1600)) - 800) : 0;
        1: c = 16'($urandom);
        2: c = 16'($signed($urandom_range(0, 130)) - 65);
        default: c = 0;
      endcase
      if (i == 0 && dc >= 0) c = dc[15:0];
      send_coefficient(c, i == 0 ? intra_in : bit'($urandom_range(0, 1)));
      if (i == 63 || $urandom_range(0, 7) == 0) begin
        in_tvalid <= 0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
      end
    end
    blocks_sent++;
  endtask

  task automatic write_quantizer(logic [4:0] q);
    while (sb.kind_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= q;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.quantizer = q;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: DC 128 escape, nonpositive DC, empty block, full range, DC clamp.
    send_block(1, 3, 1024);
    send_block(1, 0, -8);
    send_block(0, 3, -1);
    write_quantizer(5'd1);
    send_block(0, 1, -32768);
    write_quantizer(5'd0);
    send_block(1, 2, 7);
    write_quantizer(5'd31);
    hold_off = 1;
    fork
      begin
        send_block(0, 1, -1);
        send_block(1, 1, 32767);
      end
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
    join
    while (sb.kind_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d blocks, checked %0d result words over several quantizer settings.",
             blocks_sent, sb.words_checked);
    if (sb.mismatches == 0 && sb.kind_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
